@@ sv/hsv2rgb_pkg.sv @@
// Package for the HSV to RGB converter: beat structs, sector codes and
// the fixed-point constants shared by all pipeline stages.
// No dependencies.
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChW   = 8;
  localparam int unsigned RemW  = 6;
  localparam int unsigned NumW  = 13;
  localparam int unsigned ProdW = 20;
  localparam int unsigned ZW    = 18;
  localparam int unsigned RecW  = 19;
  localparam int unsigned RecSh = 28;
  localparam int unsigned QW    = 9;

  localparam logic [HueW-1:0] SectorDeg = 9'd60;
  localparam logic [NumW-1:0] FullNum   = 13'd6000;
  localparam logic [RecW-1:0] Recip625  = 19'd429497;
  localparam logic [ChW-1:0]  ChMax     = 8'd255;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueW-1:0] hue_deg;
    logic [PctW-1:0] sat_pct;
    logic [PctW-1:0] val_pct;
  } hsv_in_t;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } rgb_out_t;

  typedef struct packed {
    logic            valid;
    sector_e         sector;
    logic [RemW-1:0] rem;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
  } sec_beat_t;

  typedef struct packed {
    logic            valid;
    sector_e         sector;
    logic [PctW-1:0] val;
    logic [NumW-1:0] num_p;
    logic [NumW-1:0] num_q;
    logic [NumW-1:0] num_t;
  } term_beat_t;

  function automatic logic [NumW-1:0] clamp_num(input logic [NumW-1:0] sub);
    logic [NumW-1:0] res;
    res = (sub >= FullNum) ? '0 : (FullNum - sub);
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/hsv2rgb_sector.sv @@
// Stage one: splits the hue into its sector and the position within it.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_sector (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  hsv2rgb_pkg::hsv_in_t   data_i,
  output hsv2rgb_pkg::sec_beat_t beat_o
);
  import hsv2rgb_pkg::*;

  logic            valid_q;
  sector_e         sector_d, sector_q;
  logic [RemW-1:0] rem_d, rem_q;
  logic [PctW-1:0] sat_q, val_q;
  logic [3:0]      quot;
  logic [HueW-1:0] base;
  logic [HueW-1:0] diff;

  always_comb begin
    quot = '0;
    for (int k = 1; k <= 8; k++) begin
      if (data_i.hue_deg >= HueW'(k * 60)) begin
        quot = quot + 4'd1;
      end
    end
    base     = HueW'(quot) * SectorDeg;
    diff     = data_i.hue_deg - base;
    rem_d    = diff[RemW-1:0];
    sector_d = sector_e'((quot >= 4'd6) ? 3'(quot - 4'd6) : quot[2:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    rem_q    <= rem_d;
    sat_q    <= data_i.sat_pct;
    val_q    <= data_i.val_pct;
  end

  assign beat_o = '{valid: valid_q, sector: sector_q, rem: rem_q, sat: sat_q, val: val_q};

endmodule

`default_nettype wire

@@ sv/hsv2rgb_terms.sv @@
// Stage two: forms the p, q and t numerators, clamped at zero.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_terms (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hsv2rgb_pkg::sec_beat_t  beat_i,
  output hsv2rgb_pkg::term_beat_t beat_o
);
  import hsv2rgb_pkg::*;

  logic            valid_q;
  sector_e         sector_q;
  logic [PctW-1:0] val_q;
  logic [NumW-1:0] num_p_d, num_q_d, num_t_d;
  logic [NumW-1:0] num_p_q, num_q_q, num_t_q;
  logic [RemW-1:0] rem_inv;

  always_comb begin
    rem_inv = RemW'(SectorDeg) - beat_i.rem;
    num_p_d = clamp_num(NumW'(SectorDeg) * NumW'(beat_i.sat));
    num_q_d = clamp_num(NumW'(beat_i.rem) * NumW'(beat_i.sat));
    num_t_d = clamp_num(NumW'(rem_inv) * NumW'(beat_i.sat));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= beat_i.sector;
    val_q    <= beat_i.val;
    num_p_q  <= num_p_d;
    num_q_q  <= num_q_d;
    num_t_q  <= num_t_d;
  end

  assign beat_o = '{valid: valid_q, sector: sector_q, val: val_q,
                    num_p: num_p_q, num_q: num_q_q, num_t: num_t_q};

endmodule

`default_nettype wire

@@ sv/hsv2rgb_scale.sv @@
// Three-stage channel scaler: floor(255 * val * num / 600000), saturated.
// Divides by 40000 as a shift by 6 and a reciprocal multiply for 625.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [hsv2rgb_pkg::PctW-1:0] val_i,
  input  logic [hsv2rgb_pkg::NumW-1:0] num_i,
  output logic                         valid_o,
  output logic [hsv2rgb_pkg::ChW-1:0]  ch_o
);
  import hsv2rgb_pkg::*;

  logic [2:0]             valid_q;
  logic [ProdW-1:0]       prod_q;
  logic [ZW-1:0]          z_q;
  logic [ChW-1:0]         ch_q;
  logic [ProdW+4-1:0]     y;
  logic [ZW+RecW-1:0]     recip_prod;
  logic [QW-1:0]          quot;

  always_comb begin
    y          = {prod_q, 4'b0000} + (ProdW+4)'(prod_q);
    recip_prod = (ZW+RecW)'(z_q) * (ZW+RecW)'(Recip625);
    quot       = recip_prod[RecSh +: QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(val_i) * ProdW'(num_i);
    z_q    <= y[ProdW+4-1:6];
    ch_q   <= (quot > QW'(ChMax)) ? ChMax : quot[ChW-1:0];
  end

  assign valid_o = valid_q[2];
  assign ch_o    = ch_q;

endmodule

`default_nettype wire

@@ sv/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: sector split, term forming,
// four channel scalers and the sector routing register.
// Depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_terms, hsv2rgb_scale.
//
// Usage:
//   Drive in_i and raise start for one cycle per beat; busy is always low,
//   so a new beat may enter every clock cycle.
//   Each beat gives one RGB triple on result_o, marked by result_valid_o for
//   exactly one cycle: it passes the sector register, the term register,
//   the scaler stages and the output register in that order.
//   Throughput is one beat per cycle; every stage is a plain register stage
//   and the four channel scalers work in parallel.
//   Hue wraps every 360 degrees; saturation above 100 drives a term to zero
//   and value above 100 saturates a channel at 255.
//   Reset clears all valid bits; beats in flight are dropped.
//   The receiver cannot stall: each result must be taken in its cycle.
`default_nettype none

module hsv_to_rgb_converter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  hsv2rgb_pkg::hsv_in_t  in_i,
  output logic                  result_valid_o,
  output hsv2rgb_pkg::rgb_out_t result_o
);
  import hsv2rgb_pkg::*;

  sec_beat_t      sec_beat;
  term_beat_t     term_beat;
  logic [3:0]     ch_valid;
  logic [ChW-1:0] ch_v, ch_p, ch_q, ch_t;
  sector_e        sector_q [3];
  logic           valid_q;
  rgb_out_t       result_d, result_q;

  assign busy = 1'b0;

  hsv2rgb_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .data_i  (in_i),
    .beat_o  (sec_beat)
  );

  hsv2rgb_terms u_terms (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (sec_beat),
    .beat_o (term_beat)
  );

  hsv2rgb_scale u_scale_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (term_beat.valid),
    .val_i   (term_beat.val),
    .num_i   (FullNum),
    .valid_o (ch_valid[0]),
    .ch_o    (ch_v)
  );

  hsv2rgb_scale u_scale_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (term_beat.valid),
    .val_i   (term_beat.val),
    .num_i   (term_beat.num_p),
    .valid_o (ch_valid[1]),
    .ch_o    (ch_p)
  );

  hsv2rgb_scale u_scale_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (term_beat.valid),
    .val_i   (term_beat.val),
    .num_i   (term_beat.num_q),
    .valid_o (ch_valid[2]),
    .ch_o    (ch_q)
  );

  hsv2rgb_scale u_scale_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (term_beat.valid),
    .val_i   (term_beat.val),
    .num_i   (term_beat.num_t),
    .valid_o (ch_valid[3]),
    .ch_o    (ch_t)
  );

  always_ff @(posedge clk_i) begin
    sector_q[0] <= term_beat.sector;
    sector_q[1] <= sector_q[0];
    sector_q[2] <= sector_q[1];
  end

  always_comb begin
    unique case (sector_q[2])
      SEC_R_TO_Y: result_d = '{red: ch_v, green: ch_t, blue: ch_p};
      SEC_Y_TO_G: result_d = '{red: ch_q, green: ch_v, blue: ch_p};
      SEC_G_TO_C: result_d = '{red: ch_p, green: ch_v, blue: ch_t};
      SEC_C_TO_B: result_d = '{red: ch_p, green: ch_q, blue: ch_v};
      SEC_B_TO_M: result_d = '{red: ch_t, green: ch_p, blue: ch_v};
      default:    result_d = '{red: ch_v, green: ch_p, blue: ch_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= &ch_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

@@ dv/hsv_to_rgb_converter_test.sv @@
// Self-checking testbench for hsv_to_rgb_converter: a directed table of colors,
// then random beats with random gaps; checked against table or local model.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_converter RTL.
`default_nettype none

module hsv_to_rgb_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam longint CH_FULL     = 255;
  localparam longint DEG_PER_SEC = 60;
  localparam longint NUM_SECTORS = 6;
  localparam longint FULL_NUM    = 6000;
  localparam longint SCALE_DEN   = 600000;
  localparam int     RAND_BEATS  = 1400;
  localparam int     CALM_BEATS  = 200;
  localparam int     DRAIN_WAIT  = 12;
  localparam int     STALL_LIMIT = 1000;
  localparam int     REPORT_MAX  = 10;

  typedef struct packed {
    logic     known;
    hsv_in_t  px;
    rgb_out_t rgb;
  } color_row_t;

  localparam int NUM_ROWS = 20;

  color_row_t color_tbl [NUM_ROWS] = '{
    '{1'b1, '{9'd0,   7'd0,   7'd0},   '{8'd0,   8'd0,   8'd0}},
    '{1'b1, '{9'd0,   7'd0,   7'd100}, '{8'd255, 8'd255, 8'd255}},
    '{1'b1, '{9'd0,   7'd100, 7'd100}, '{8'd255, 8'd0,   8'd0}},
    '{1'b1, '{9'd60,  7'd100, 7'd100}, '{8'd255, 8'd255, 8'd0}},
    '{1'b1, '{9'd120, 7'd100, 7'd100}, '{8'd0,   8'd255, 8'd0}},
    '{1'b1, '{9'd180, 7'd100, 7'd100}, '{8'd0,   8'd255, 8'd255}},
    '{1'b1, '{9'd240, 7'd100, 7'd100}, '{8'd0,   8'd0,   8'd255}},
    '{1'b1, '{9'd300, 7'd100, 7'd100}, '{8'd255, 8'd0,   8'd255}},
    '{1'b1, '{9'd360, 7'd100, 7'd100}, '{8'd255, 8'd0,   8'd0}},
    '{1'b1, '{9'd420, 7'd100, 7'd100}, '{8'd255, 8'd255, 8'd0}},
    '{1'b1, '{9'd361, 7'd0,   7'd100}, '{8'd255, 8'd255, 8'd255}},
    '{1'b1, '{9'd90,  7'd0,   7'd127}, '{8'd255, 8'd255, 8'd255}},
    '{1'b0, '{9'd359, 7'd100, 7'd100}, '{8'd0,   8'd0,   8'd0}},
    '{1'b0, '{9'd59,  7'd50,  7'd80},  '{8'd0,   8'd0,   8'd0}},
    '{1'b0, '{9'd30,  7'd100, 7'd100}, '{8'd0,   8'd0,   8'd0}},
    '{1'b0, '{9'd511, 7'd127, 7'd127}, '{8'd0,   8'd0,   8'd0}},
    '{1'b0, '{9'd0,   7'd127, 7'd100}, '{8'd0,   8'd0,   8'd0}},
    '{1'b0, '{9'd200, 7'd100, 7'd127}, '{8'd0,   8'd0,   8'd0}},
    '{1'b0, '{9'd0,   7'd0,   7'd1},   '{8'd0,   8'd0,   8'd0}},
    '{1'b0, '{9'd475, 7'd85,  7'd42},  '{8'd0,   8'd0,   8'd0}}
  };

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  hsv_in_t  in_i = '0;
  logic     result_valid_o;
  rgb_out_t result_o;

  rgb_out_t pend_rgb [$];
  int       mismatches = 0;
  int       stall_cycles = 0;

  hsv_to_rgb_converter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint chan_level(longint val, longint num);
    longint lvl;
    if (num <= 0 || val <= 0) begin
      return 0;
    end
    lvl = CH_FULL * val * num / SCALE_DEN;
    return (lvl > CH_FULL) ? CH_FULL : lvl;
  endfunction

  function automatic rgb_out_t hsv_color(hsv_in_t px);
    longint   hue;
    longint   sat;
    longint   val;
    longint   sec;
    longint   rem;
    longint   cv;
    longint   cp;
    longint   cq;
    longint   ct;
    rgb_out_t rgb;
    hue = longint'(px.hue_deg);
    sat = longint'(px.sat_pct);
    val = longint'(px.val_pct);
    sec = (hue / DEG_PER_SEC) % NUM_SECTORS;
    rem = hue % DEG_PER_SEC;
    cv  = chan_level(val, FULL_NUM);
    cp  = chan_level(val, FULL_NUM - DEG_PER_SEC * sat);
    cq  = chan_level(val, FULL_NUM - rem * sat);
    ct  = chan_level(val, FULL_NUM - (DEG_PER_SEC - rem) * sat);
    case (sector_e'(sec[2:0]))
      SEC_R_TO_Y: rgb = {cv[7:0], ct[7:0], cp[7:0]};
      SEC_Y_TO_G: rgb = {cq[7:0], cv[7:0], cp[7:0]};
      SEC_G_TO_C: rgb = {cp[7:0], cv[7:0], ct[7:0]};
      SEC_C_TO_B: rgb = {cp[7:0], cq[7:0], cv[7:0]};
      SEC_B_TO_M: rgb = {ct[7:0], cp[7:0], cv[7:0]};
      default:    rgb = {cv[7:0], cp[7:0], cq[7:0]};
    endcase
    return rgb;
  endfunction

  function automatic hsv_in_t rand_color();
    hsv_in_t px;
    int      pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      px.hue_deg = 9'($urandom_range(0, 360));
    end else if (pick < 8) begin
      px.hue_deg = 9'($urandom_range(0, 6) * DEG_PER_SEC + $urandom_range(0, 1) * 59);
    end else begin
      px.hue_deg = 9'($urandom_range(361, 511));
    end
    pick = $urandom_range(0, 9);
    px.sat_pct = (pick < 7) ? 7'($urandom_range(0, 100)) :
                 (pick < 9) ? 7'($urandom_range(0, 1) * 100) : 7'($urandom_range(101, 127));
    pick = $urandom_range(0, 9);
    px.val_pct = (pick < 7) ? 7'($urandom_range(0, 100)) :
                 (pick < 9) ? 7'($urandom_range(0, 1) * 100) : 7'($urandom_range(101, 127));
    return px;
  endfunction

  task automatic send_color(hsv_in_t px, logic known, rgb_out_t rgb);
    start <= 1'b1;
    in_i  <= px;
    do @(posedge clk_i); while (busy);
    pend_rgb.push_back(known ? rgb : hsv_color(px));
  endtask

  task automatic start_gap();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      in_i  <= hsv_in_t'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    rgb_out_t exp_rgb;
    if ((start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (result_valid_o) begin
      if (pend_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected beat: r=%0d g=%0d b=%0d",
                   result_o.red, result_o.green, result_o.blue);
        end
      end else begin
        exp_rgb = pend_rgb.pop_front();
        if (result_o.red !== exp_rgb.red || result_o.green !== exp_rgb.green ||
            result_o.blue !== exp_rgb.blue) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                     result_o.red, result_o.green, result_o.blue);
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_color(color_tbl[i].px, color_tbl[i].known, color_tbl[i].rgb);
      start_gap();
    end
    for (int i = 0; i < RAND_BEATS; i++) begin
      send_color(rand_color(), 1'b0, '0);
      if (i < RAND_BEATS - CALM_BEATS) begin
        start_gap();
      end
    end
    start <= 1'b0;
    while (pend_rgb.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pend_rgb.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_sector.sv
sv/hsv2rgb_terms.sv
sv/hsv2rgb_scale.sv
sv/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_converter_test.sv
